// ----- sv/eir_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eir_pkg: shared types and constants of the exact integer nth root core
// Widths, the controller states and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package eir_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned ExpBits   = 6;
  localparam int unsigned InBits    = ExpBits + 32;
  localparam int unsigned InBytes   = (InBits + 7) / 8;
  localparam int unsigned InDataW   = InBytes * 8;
  localparam int unsigned OutDataW  = 32;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_POW    = 5'b00100,
    ST_CMP    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  typedef struct packed {
    logic load_in;
    logic start_trial;
    logic mul;
    logic acc_take;
    logic go_up;
    logic go_down;
    logic set_hit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic k_done;
    logic acc_eq;
    logic acc_lt;
    logic prod_gt;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/eir_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eir_dpath: search datapath
// Holds the search bounds, the trial root, the running power and the
// registered product of the shared multiplier, plus the result register.
// ----------------------------------------------------------------------------
module eir_dpath
  import eir_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic [ExpBits-1:0]   exponent_i,
  input  wire logic [31:0]          value_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic                      found_o,
  output logic [31:0]               root_o
);

  logic [ValueBits-1:0]   m_q;
  logic [ExpBits-1:0]     n_q;
  logic [ExpBits-1:0]     k_q;
  logic [ValueBits:0]     lo_q;
  logic [ValueBits-1:0]   hi_q;
  logic [ValueBits-1:0]   mid_q;
  logic [ValueBits-1:0]   acc_q;
  logic [2*ValueBits-1:0] prod_q;
  logic                   hit_q;
  logic                   found_q;
  logic [31:0]            root_q;
  logic [ValueBits+1:0]   sum;
  logic [ValueBits-1:0]   mid_d;

  assign sum   = (ValueBits+2)'(lo_q) + (ValueBits+2)'(hi_q);
  assign mid_d = sum[ValueBits:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      m_q   <= value_i[ValueBits-1:0];
      n_q   <= exponent_i;
      lo_q  <= (ValueBits+1)'(1);
      hi_q  <= value_i[ValueBits-1:0];
      hit_q <= 1'b0;
    end
    if (cmd_i.start_trial) begin
      mid_q <= mid_d;
      acc_q <= ValueBits'(1);
      k_q   <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= (2*ValueBits)'(acc_q) * (2*ValueBits)'(mid_q);
      k_q    <= k_q + ExpBits'(1);
    end
    if (cmd_i.acc_take) begin
      acc_q <= prod_q[ValueBits-1:0];
    end
    if (cmd_i.go_up) begin
      lo_q <= (ValueBits+1)'(mid_q) + (ValueBits+1)'(1);
    end
    if (cmd_i.go_down) begin
      hi_q <= mid_q - ValueBits'(1);
    end
    if (cmd_i.set_hit) begin
      hit_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      found_q <= hit_q;
      root_q  <= hit_q ? 32'(mid_q) : 32'd0;
    end
  end

  assign sts_o.lo_gt_hi = lo_q > (ValueBits+1)'(hi_q);
  assign sts_o.k_done   = k_q == n_q;
  assign sts_o.acc_eq   = acc_q == m_q;
  assign sts_o.acc_lt   = acc_q < m_q;
  assign sts_o.prod_gt  = prod_q > (2*ValueBits)'(m_q);

  assign found_o = found_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire

// ----- sv/eir_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eir_ctrl: search controller
// Sequences bisection steps and the repeated multiplication of each trial,
// and owns the request handshakes on both sides.
// ----------------------------------------------------------------------------
module eir_ctrl
  import eir_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.lo_gt_hi) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.start_trial = 1'b1;
          state_d           = ST_POW;
        end
      end
      ST_POW: begin
        if (!sts_i.k_done) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_CMP;
        end else if (sts_i.acc_eq) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_FIN;
        end else if (sts_i.acc_lt) begin
          cmd_o.go_up = 1'b1;
          state_d     = ST_SEARCH;
        end else begin
          cmd_o.go_down = 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      ST_CMP: begin
        if (sts_i.prod_gt) begin
          cmd_o.go_down = 1'b1;
          state_d       = ST_SEARCH;
        end else begin
          cmd_o.acc_take = 1'b1;
          state_d        = ST_POW;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- sv/exact_integer_nth_root_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// exact_integer_nth_root_core: exact integer nth root by bisection
// Finds r with r^n == m, or reports that none exists.
// ----------------------------------------------------------------------------
// Each request carries an exponent n and a value m; the core bisects 1..m
// and returns found plus the exact root (root 0 when not found; m of zero
// gives not found, n of zero finds only m == 1). One request is worked at a
// time. Each bisection step starts a trial root and raises it to the power n
// by repeated multiplication, ending the step early when a partial product
// passes m; a request takes at most 32 bisection steps. The single shared
// 32x32 multiplier is registered before its compare. A finished result waits
// in an output register, so the next request is taken while it is still
// unread.
// ----------------------------------------------------------------------------
module exact_integer_nth_root_core
  import eir_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [5:0] exponent, [37:6] value
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [31:0] root
  output logic                     m_axis_tuser    // [0] found
);

  cmd_t cmd;
  sts_t sts;

  eir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eir_dpath u_dpath (
    .clk_i      (clk_i),
    .exponent_i (s_axis_tdata[ExpBits-1:0]),
    .value_i    (s_axis_tdata[ExpBits+31:ExpBits]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .found_o    (m_axis_tuser),
    .root_o     (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- sv/eir_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eir_checker: port-level checks of the nth root core
// Watches the request handshakes and the result encoding over time.
// ----------------------------------------------------------------------------
module eir_checker
  import eir_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("root not zero on a miss");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
    else $error("zero root reported as found");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a search is running");

endmodule

bind exact_integer_nth_root_core eir_checker u_eir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
